// ----- design/kz_pkg.sv -----
// Package: shared types, tables and field math for the Kuznyechik CBC engine.
package kz_pkg;

    // Block as sixteen bytes, byte 0 in the most significant position
    typedef logic [0:15][7:0] t_blk;
    typedef logic [0:15][0:15][7:0] t_mat;
    typedef logic [0:255][7:0] t_sbox;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_IV_HIGH = 2'd1,
        CFG_IV_LOW  = 2'd2,
        CFG_UNUSED  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // Round control handed to the datapath
    typedef struct packed {
        logic dec;
        logic first;
        logic last;
    } t_round_ctl;

    localparam logic [7:0] POLY_LOW = 8'hC3;
    localparam logic [7:0] MSB_MASK = 8'h80;

    localparam t_sbox SBOX = {
        8'd252, 8'd238, 8'd221, 8'd17,  8'd207, 8'd110, 8'd49,  8'd22,
        8'd251, 8'd196, 8'd250, 8'd218, 8'd35,  8'd197, 8'd4,   8'd77,
        8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46,  8'd153, 8'd186,
        8'd23,  8'd54,  8'd241, 8'd187, 8'd20,  8'd205, 8'd95,  8'd193,
        8'd249, 8'd24,  8'd101, 8'd90,  8'd226, 8'd92,  8'd239, 8'd33,
        8'd129, 8'd28,  8'd60,  8'd66,  8'd139, 8'd1,   8'd142, 8'd79,
        8'd5,   8'd132, 8'd2,   8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
        8'd6,   8'd11,  8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
        8'd235, 8'd52,  8'd44,  8'd81,  8'd234, 8'd200, 8'd72,  8'd171,
        8'd242, 8'd42,  8'd104, 8'd162, 8'd253, 8'd58,  8'd206, 8'd204,
        8'd181, 8'd112, 8'd14,  8'd86,  8'd8,   8'd12,  8'd118, 8'd18,
        8'd191, 8'd114, 8'd19,  8'd71,  8'd156, 8'd183, 8'd93,  8'd135,
        8'd21,  8'd161, 8'd150, 8'd41,  8'd16,  8'd123, 8'd154, 8'd199,
        8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
        8'd50,  8'd117, 8'd25,  8'd61,  8'd255, 8'd53,  8'd138, 8'd126,
        8'd109, 8'd84,  8'd198, 8'd128, 8'd195, 8'd189, 8'd13,  8'd87,
        8'd223, 8'd245, 8'd36,  8'd169, 8'd62,  8'd168, 8'd67,  8'd201,
        8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34,  8'd185, 8'd3,
        8'd224, 8'd15,  8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
        8'd220, 8'd232, 8'd40,  8'd80,  8'd78,  8'd51,  8'd10,  8'd74,
        8'd167, 8'd151, 8'd96,  8'd115, 8'd30,  8'd0,   8'd98,  8'd68,
        8'd26,  8'd184, 8'd56,  8'd130, 8'd100, 8'd159, 8'd38,  8'd65,
        8'd173, 8'd69,  8'd70,  8'd146, 8'd39,  8'd94,  8'd85,  8'd47,
        8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
        8'd7,   8'd88,  8'd179, 8'd64,  8'd134, 8'd172, 8'd29,  8'd247,
        8'd48,  8'd55,  8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
        8'd225, 8'd27,  8'd131, 8'd73,  8'd76,  8'd63,  8'd248, 8'd254,
        8'd141, 8'd83,  8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
        8'd32,  8'd113, 8'd103, 8'd164, 8'd45,  8'd43,  8'd9,   8'd91,
        8'd203, 8'd155, 8'd37,  8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
        8'd89,  8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
        8'd209, 8'd102, 8'd175, 8'd194, 8'd57,  8'd75,  8'd99,  8'd182
    };

    localparam t_blk LIN_COEF = {
        8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
        8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
    };

    // GF(2^8) multiply, reduction x^8+x^7+x^6+x+1
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) begin
                acc = acc ^ x;
            end
            if ((x & MSB_MASK) != 8'd0) begin
                x = {x[6:0], 1'b0} ^ POLY_LOW;
            end else begin
                x = {x[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // Sixteen forward R steps
    function automatic t_blk lin_fwd(input t_blk b_in);
        t_blk b;
        logic [7:0] s;
        b = b_in;
        for (int st = 0; st < 16; st++) begin
            s = '0;
            for (int j = 0; j < 16; j++) begin
                s = s ^ gf_mul(b[j], LIN_COEF[j]);
            end
            for (int j = 15; j > 0; j--) begin
                b[j] = b[j-1];
            end
            b[0] = s;
        end
        return b;
    endfunction

    // Sixteen inverse R steps
    function automatic t_blk lin_inv(input t_blk b_in);
        t_blk b;
        logic [7:0] s;
        b = b_in;
        for (int st = 0; st < 16; st++) begin
            s = b[0];
            for (int j = 0; j < 15; j++) begin
                b[j] = b[j+1];
                s = s ^ gf_mul(b[j], LIN_COEF[j]);
            end
            b[15] = s;
        end
        return b;
    endfunction

    // Coefficient matrix of L (or its inverse), column j is the image of unit byte j
    function automatic t_mat build_mat(input logic inv);
        t_mat m;
        t_blk e;
        m = '0;
        for (int j = 0; j < 16; j++) begin
            e    = '0;
            e[j] = 8'd1;
            e    = inv ? lin_inv(e) : lin_fwd(e);
            for (int i = 0; i < 16; i++) begin
                m[i][j] = e[i];
            end
        end
        return m;
    endfunction

    function automatic t_sbox build_inv_sbox();
        t_sbox r;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            r[SBOX[i]] = 8'(i);
        end
        return r;
    endfunction

    localparam t_mat  L_FWD   = build_mat(1'b0);
    localparam t_mat  L_INV   = build_mat(1'b1);
    localparam t_sbox SBOX_INV = build_inv_sbox();

endpackage

// ----- design/kz_key_ram.sv -----
// Round key memory: one write port, one registered read port.
module kz_key_ram #(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [127:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [127:0]  o_rdata
);

    logic [127:0] r_mem [DEPTH];
    logic [127:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held when no read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/kz_round.sv -----
// One cipher round step, forward or inverse, with the linear layer as a constant matrix.
module kz_round (
    input  kz_pkg::t_blk       i_x,
    input  kz_pkg::t_blk       i_key,
    input  kz_pkg::t_round_ctl i_ctl,
    output kz_pkg::t_blk       o_y
);

    kz_pkg::t_blk xk;
    kz_pkg::t_blk sb;
    kz_pkg::t_blk lf;
    kz_pkg::t_blk li;
    kz_pkg::t_blk si;

    // forward: S then L on x ^ key
    always_comb begin
        xk = i_x ^ i_key;
        for (int i = 0; i < 16; i++) begin
            sb[i] = kz_pkg::SBOX[xk[i]];
        end
        for (int i = 0; i < 16; i++) begin
            lf[i] = '0;
            for (int j = 0; j < 16; j++) begin
                lf[i] = lf[i] ^ kz_pkg::gf_mul(sb[j], kz_pkg::L_FWD[i][j]);
            end
        end
    end

    // inverse: L^-1 then S^-1 on x, key added after
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            li[i] = '0;
            for (int j = 0; j < 16; j++) begin
                li[i] = li[i] ^ kz_pkg::gf_mul(i_x[j], kz_pkg::L_INV[i][j]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            si[i] = kz_pkg::SBOX_INV[li[i]];
        end
    end

    // final encrypt step and first decrypt step are a bare key add
    always_comb begin
        if (i_ctl.dec) begin
            o_y = i_ctl.first ? xk : (si ^ i_key);
        end else begin
            o_y = i_ctl.last ? xk : lf;
        end
    end

endmodule

// ----- design/block_cipher_128_cbc_engine_core.sv -----
// Top level: Kuznyechik block engine with key memory, round sequencer and CBC chaining.
// Operation: a block uses one round key per round step, each read from the key memory
//   ahead of its use; a finished block waits while the previous result still sits
//   unaccepted in the output register.
// Input is taken only while idle: no block or key load is accepted while a block runs.
// Reset: synchronous active low; clears control, config and chain; key memory is not cleared.
module block_cipher_128_cbc_engine_core #(
    parameter int NUM_ROUND_KEYS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // word_high[63:0], word_low[127:64]
    input  logic [6:0]   s_axis_tuser,  // op[1:0], key_slot[5:2], first_block[6]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_high[63:0], result_low[127:64]
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);

    localparam int KW = (NUM_ROUND_KEYS > 1) ? $clog2(NUM_ROUND_KEYS) : 1;
    localparam logic [KW-1:0] LAST = KW'(NUM_ROUND_KEYS - 1);

    kz_pkg::t_state r_state, n_state;
    logic [KW-1:0]  r_cnt, n_cnt;
    logic           r_dec;
    logic           r_cm;
    logic [63:0]    r_iv_hi, r_iv_lo;
    kz_pkg::t_blk   r_x;
    kz_pkg::t_blk   r_feed;
    kz_pkg::t_blk   r_chain;
    logic           r_out_valid;
    logic [127:0]   r_out_data;

    kz_pkg::t_op    in_op;
    logic [3:0]     in_slot;
    logic           in_first;
    kz_pkg::t_blk   in_blk;
    logic           acc;
    logic           go;
    logic           key_we;
    logic           key_re;
    logic [KW-1:0]  key_raddr;
    logic [127:0]   key_rdata;
    logic           out_free;
    logic           finish;
    kz_pkg::t_round_ctl ctl;
    kz_pkg::t_blk   rnd_y;
    kz_pkg::t_blk   feed_sel;

    // input word decode
    assign in_op    = kz_pkg::t_op'(s_axis_tuser[1:0]);
    assign in_slot  = s_axis_tuser[5:2];
    assign in_first = s_axis_tuser[6];
    assign in_blk   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    assign s_axis_tready = (r_state == kz_pkg::ST_IDLE);
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign go       = acc && (in_op == kz_pkg::OP_ENC || in_op == kz_pkg::OP_DEC);
    assign key_we   = acc && (in_op == kz_pkg::OP_LOAD) && (32'(in_slot) < NUM_ROUND_KEYS);
    assign out_free = !r_out_valid || m_axis_tready;
    assign feed_sel = in_first ? kz_pkg::t_blk'({r_iv_hi, r_iv_lo}) : r_chain;

    kz_key_ram #(
        .DEPTH (NUM_ROUND_KEYS),
        .AW    (KW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (KW'(in_slot)),
        .i_wdata (in_blk),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    assign ctl.dec   = r_dec;
    assign ctl.first = (r_cnt == '0);
    assign ctl.last  = (r_cnt == LAST);

    kz_round u_round (
        .i_x   (r_x),
        .i_key (kz_pkg::t_blk'(key_rdata)),
        .i_ctl (ctl),
        .o_y   (rnd_y)
    );

    // sequencer: one key per cycle, last step waits on output; key read the cycle before use
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        key_re    = 1'b0;
        key_raddr = '0;
        finish    = 1'b0;
        unique case (r_state)
            kz_pkg::ST_IDLE: begin
                if (go) begin
                    n_state   = kz_pkg::ST_RUN;
                    n_cnt     = '0;
                    key_re    = 1'b1;
                    key_raddr = (in_op == kz_pkg::OP_DEC) ? LAST : '0;
                end
            end
            kz_pkg::ST_RUN: begin
                if (r_cnt != LAST) begin
                    n_cnt     = r_cnt + KW'(1);
                    key_re    = 1'b1;
                    key_raddr = r_dec ? (LAST - r_cnt - KW'(1)) : (r_cnt + KW'(1));
                end else if (out_free) begin
                    n_state = kz_pkg::ST_IDLE;
                    finish  = 1'b1;
                end
            end
            default: begin
                n_state = kz_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kz_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm    <= 1'b0;
            r_iv_hi <= '0;
            r_iv_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (kz_pkg::t_cfg_idx'(i_cfg_idx))
                kz_pkg::CFG_MODE:    r_cm    <= i_cfg_data[0];
                kz_pkg::CFG_IV_HIGH: r_iv_hi <= i_cfg_data;
                kz_pkg::CFG_IV_LOW:  r_iv_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // block state, feedback word and chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (go && r_cm && in_op == kz_pkg::OP_DEC) begin
            r_chain <= in_blk;
        end else if (finish && r_cm && !r_dec) begin
            r_chain <= rnd_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_dec  <= (in_op == kz_pkg::OP_DEC);
            r_feed <= feed_sel;
            if (r_cm && in_op == kz_pkg::OP_ENC) begin
                r_x <= in_blk ^ feed_sel;
            end else begin
                r_x <= in_blk;
            end
        end else if (r_state == kz_pkg::ST_RUN && r_cnt != LAST) begin
            r_x <= rnd_y;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_dec && r_cm) begin
                r_out_data <= rnd_y ^ r_feed;
            end else begin
                r_out_data <= rnd_y;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_data[63:0], r_out_data[127:64]};

    // a block in flight blocks the input
    a_busy_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> !s_axis_tready)
        else $error("input ready while a block runs");

    // round counter stays within the key schedule
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST)
        else $error("round counter past last key");

    // a new result only appears at the end of a run
    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == kz_pkg::ST_RUN && $past(r_cnt) == LAST))
        else $error("result without a finished run");

endmodule
